>>> rtl/sat_pkg.sv
// Shared types and constants for the section address translator.
`default_nettype none

package sat_pkg;

  // Table size and field widths.
  localparam int MAX_SECTIONS = 16;
  localparam int IDX_W        = 4;
  localparam int ADDR_W       = 32;
  localparam int CNT_W        = 5;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 2'd1;

  // Request kinds.
  localparam logic REQ_LOAD      = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  localparam logic [ADDR_W-1:0] IMAGE_BASE_RESET = 32'h0040_0000;

  // Token that walks the chain of section cells.
  typedef struct packed {
    logic              live;
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] fbase;
    logic [ADDR_W-1:0] rva;
    logic [CNT_W-1:0]  limit;
    logic              found;
    logic [ADDR_W-1:0] offset;
    logic [IDX_W-1:0]  match_idx;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/sat_cell.sv
// One section cell: holds one entry, loads it or tests a passing address.
`default_nettype none

module sat_cell import sat_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [ADDR_W-1:0] section_start;
  logic [ADDR_W-1:0] section_span;
  logic [ADDR_W-1:0] section_file_base;

  logic [ADDR_W-1:0] end_addr;
  logic              covered;
  logic              in_range;
  tok_t              tok_next;

  // Range test against this cell's entry; the end wraps at 32 bits.
  always_comb begin
    end_addr = section_start + section_span;
    covered  = (tok_in.rva >= section_start) && (tok_in.rva < end_addr);
    in_range = {1'b0, cell_id} < tok_in.limit;
    tok_next = tok_in;
    if (tok_in.live && (tok_in.kind == REQ_TRANSLATE) && !tok_in.found &&
        in_range && covered) begin
      tok_next.found     = 1'b1;
      tok_next.offset    = tok_in.rva - section_start + section_file_base;
      tok_next.match_idx = cell_id;
    end
  end

  // A load item writes the entry when it passes the cell it names.
  always_ff @(posedge clk) begin
    if (tok_in.live && (tok_in.kind == REQ_LOAD) && (tok_in.idx == cell_id)) begin
      section_start     <= tok_in.start;
      section_span      <= tok_in.span;
      section_file_base <= tok_in.fbase;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/section_address_translator.sv
// Top level of the section address translator: request intake, cell chain, result register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   req_type, entry_*, virtual_address
//   out      output     out_valid / out_stall file_offset, hit, matched_index
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An accepted item passes through the intake register, which loads at the accepting edge,
// then through one register per section cell, then into the result register. The block
// holds one item at a time: in_stall is high from acceptance until the result is taken.
// A stalled result holds its value. Reset is synchronous and clears the control state
// and the registers; section entries hold no value until they are loaded.
`default_nettype none

module section_address_translator import sat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [IDX_W-1:0]     entry_index,
  input  logic [ADDR_W-1:0]    entry_start,
  input  logic [ADDR_W-1:0]    entry_virtual_size,
  input  logic [ADDR_W-1:0]    entry_raw_size,
  input  logic [ADDR_W-1:0]    entry_raw_pointer,
  input  logic [ADDR_W-1:0]    virtual_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    file_offset,
  output logic                 hit,
  output logic [IDX_W-1:0]     matched_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] image_base;
  logic [CNT_W-1:0]  section_count;
  logic              in_accept;
  tok_t              tok_new;
  tok_t              tok_head;
  tok_t              chain [MAX_SECTIONS+1];
  logic [MAX_SECTIONS:0] live_vec;
  tok_t              tok_exit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_SEND);
  assign in_accept = in_valid && !in_stall;
  assign tok_exit  = chain[MAX_SECTIONS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_base    <= IMAGE_BASE_RESET;
      section_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_BASE:    image_base    <= cfg_data;
        REG_SECTION_COUNT: section_count <= cfg_data[CNT_W-1:0];
        default:           ;
      endcase
    end
  end

  // Build the token for a new item: span and relative address are formed here.
  always_comb begin
    tok_new           = '0;
    tok_new.live      = in_accept;
    tok_new.kind      = req_type;
    tok_new.idx       = entry_index;
    tok_new.start     = entry_start;
    tok_new.span      = (entry_virtual_size > entry_raw_size) ? entry_virtual_size
                                                              : entry_raw_size;
    tok_new.fbase     = entry_raw_pointer;
    tok_new.rva       = virtual_address - image_base;
    tok_new.limit     = section_count;
  end

  // Intake register feeding the first cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head <= '0;
    end else begin
      tok_head <= tok_new;
    end
  end

  assign chain[0] = tok_head;

  // Chain of section cells, one entry each.
  assign live_vec[0] = chain[0].live;
  for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
    sat_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (IDX_W'(k)),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
    assign live_vec[k+1] = chain[k+1].live;
  end

  // Sequencer: accept, walk the chain, present the result.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_accept) state_next = ST_RUN;
      ST_RUN:  if (tok_exit.live) state_next = ST_SEND;
      ST_SEND: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register, loaded when the token leaves the last cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      file_offset   <= '0;
      hit           <= 1'b0;
      matched_index <= '0;
    end else if (tok_exit.live) begin
      file_offset   <= tok_exit.offset;
      hit           <= tok_exit.found;
      matched_index <= tok_exit.match_idx;
    end
  end

`ifndef ASSERT_OFF
  // At most one item is in the chain.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(live_vec))
    else $error("more than one item in the cell chain");

  // No token is in flight while the block is idle or presenting a result.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> (live_vec == '0))
    else $error("token in chain outside the run state");

  // An accepted item enters the intake register on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> chain[0].live)
    else $error("accepted item did not enter the chain");

  // A miss reports zero offset and zero index.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> ((file_offset == '0) && (matched_index == '0)))
    else $error("miss result carries nonzero fields");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the section address translator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam int ITEMS   = 1400;
  localparam int LATENCY = MAX_SECTIONS + 2;
  localparam int LIMIT_NS = 10_000_000;

  // One input item as the block sees it.
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] vsize;
    logic [ADDR_W-1:0] rsize;
    logic [ADDR_W-1:0] rptr;
    logic [ADDR_W-1:0] va;
  } section_req_t;

  // One result item.
  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic              hit;
    logic [IDX_W-1:0]  idx;
  } xlat_res_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // A row of the directed plan: either an item or a register write.
  typedef struct {
    row_kind_t             kind;
    section_req_t          req;
    logic                  typed;
    xlat_res_t             want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [ADDR_W-1:0]     reg_val;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 req_type = REQ_LOAD;
  logic [IDX_W-1:0]     entry_index = '0;
  logic [ADDR_W-1:0]    entry_start = '0;
  logic [ADDR_W-1:0]    entry_virtual_size = '0;
  logic [ADDR_W-1:0]    entry_raw_size = '0;
  logic [ADDR_W-1:0]    entry_raw_pointer = '0;
  logic [ADDR_W-1:0]    virtual_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    file_offset;
  logic                 hit;
  logic [IDX_W-1:0]     matched_index;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_BASE;
  logic [ADDR_W-1:0]    cfg_data = '0;

  section_address_translator dut (.*);

  // Shadow copy of the section table and the registers.
  logic [ADDR_W-1:0] sec_start [MAX_SECTIONS];
  logic [ADDR_W-1:0] sec_span  [MAX_SECTIONS];
  logic [ADDR_W-1:0] sec_fbase [MAX_SECTIONS];
  logic [ADDR_W-1:0] base_m  = IMAGE_BASE_RESET;
  logic [CNT_W-1:0]  count_m = '0;

  xlat_res_t expected_xlat[$];
  plan_row_t plan[$];

  int  mismatches = 0;
  int  n_loads = 0;
  int  n_xlat = 0;
  int  n_hits = 0;
  int  n_writes = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #LIMIT_NS;
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one item to the shadow table and work out its result.
  function automatic xlat_res_t predict_translation(section_req_t r);
    xlat_res_t         res;
    logic [ADDR_W-1:0] rva;
    logic [ADDR_W-1:0] stop;
    int                lim;
    res = '0;
    if (r.kind == REQ_LOAD) begin
      sec_start[r.idx] = r.start;
      sec_span[r.idx]  = (r.vsize > r.rsize) ? r.vsize : r.rsize;
      sec_fbase[r.idx] = r.rptr;
    end else begin
      rva = r.va - base_m;
      lim = (count_m > MAX_SECTIONS) ? MAX_SECTIONS : int'(count_m);
      for (int k = 0; k < lim && !res.hit; k++) begin
        // The end wraps at 32 bits, so a wrapping entry covers nothing above its start.
        stop = sec_start[k] + sec_span[k];
        if (rva >= sec_start[k] && rva < stop) begin
          res.offset = rva - sec_start[k] + sec_fbase[k];
          res.hit    = 1'b1;
          res.idx    = k[IDX_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Section sizes are mostly small so that entries do not cover everything.
  function automatic logic [ADDR_W-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 'h8000);
  endfunction

  function automatic section_req_t random_load(logic [IDX_W-1:0] slot);
    section_req_t r;
    r.kind  = REQ_LOAD;
    r.idx   = slot;
    r.start = $urandom;
    r.vsize = pick_size();
    r.rsize = pick_size();
    r.rptr  = $urandom;
    r.va    = $urandom;
    return r;
  endfunction

  // Most addresses are aimed at a searched entry, inside it or on its edges.
  function automatic section_req_t random_translate();
    section_req_t      r;
    int                lim;
    int                k;
    logic [ADDR_W-1:0] rva;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] sp;
    r = random_load(IDX_W'($urandom_range(0, MAX_SECTIONS - 1)));
    r.kind = REQ_TRANSLATE;
    lim = (count_m > MAX_SECTIONS) ? MAX_SECTIONS : int'(count_m);
    rva = $urandom;
    if (lim != 0 && $urandom_range(0, 9) < 7) begin
      k  = $urandom_range(0, lim - 1);
      s  = sec_start[k];
      sp = sec_span[k];
      case ($urandom_range(0, 5))
        0: rva = s;
        1: rva = s + sp - 1;
        2: rva = s + sp;
        3: rva = s - 1;
        default: rva = s + ((sp == 0) ? '0 : ADDR_W'($urandom % sp));
      endcase
    end
    r.va = rva + base_m;
    return r;
  endfunction

  function automatic plan_row_t load_row(logic [IDX_W-1:0] slot, logic [ADDR_W-1:0] start,
                                         logic [ADDR_W-1:0] vsize, logic [ADDR_W-1:0] rsize,
                                         logic [ADDR_W-1:0] rptr);
    plan_row_t row;
    row.kind = ROW_ITEM;
    row.req  = '{REQ_LOAD, slot, start, vsize, rsize, rptr, '1};
    row.typed = 1'b1;
    row.want  = '0;
    row.reg_idx = REG_IMAGE_BASE;
    row.reg_val = '0;
    return row;
  endfunction

  function automatic plan_row_t xlat_row(logic [ADDR_W-1:0] va, logic typed, xlat_res_t want);
    plan_row_t row;
    row.kind = ROW_ITEM;
    row.req  = '{REQ_TRANSLATE, '0, '0, '0, '0, '0, va};
    row.typed = typed;
    row.want  = want;
    row.reg_idx = REG_IMAGE_BASE;
    row.reg_val = '0;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    plan_row_t row;
    row.kind = ROW_REG;
    row.req  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Present one item, hold it until accepted, then record what should come back.
  task automatic send_req(section_req_t r, logic typed, xlat_res_t want);
    int        gap;
    xlat_res_t got;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type           <= r.kind;
    entry_index        <= r.idx;
    entry_start        <= r.start;
    entry_virtual_size <= r.vsize;
    entry_raw_size     <= r.rsize;
    entry_raw_pointer  <= r.rptr;
    virtual_address    <= r.va;
    in_valid           <= 1'b1;
    do @(posedge clk); while (in_stall);
    got = predict_translation(r);
    expected_xlat.push_back(typed ? want : got);
    if (r.kind == REQ_LOAD) begin
      n_loads++;
    end else begin
      n_xlat++;
      if (got.hit) n_hits++;
    end
  endtask

  // Stop sending and let every outstanding result drain out of the block.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_xlat.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_BASE) base_m = val;
    else count_m = val[CNT_W-1:0];
    n_writes++;
  endtask

  // The result side stalls in random bursts, except during calm phases.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall || calm) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    xlat_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_xlat.size() == 0) begin
        $error("result item with nothing expected: file_offset %h hit %b matched_index %0d",
               file_offset, hit, matched_index);
        mismatches++;
      end else begin
        want = expected_xlat.pop_front();
        if (file_offset !== want.offset) begin
          $error("file_offset: expected %h, got %h", want.offset, file_offset);
          mismatches++;
        end
        if (hit !== want.hit) begin
          $error("hit: expected %b, got %b", want.hit, hit);
          mismatches++;
        end
        if (matched_index !== want.idx) begin
          $error("matched_index: expected %0d, got %0d", want.idx, matched_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    plan_row_t         row;
    section_req_t      r;
    logic [ADDR_W-1:0] base_pick;
    logic [ADDR_W-1:0] count_pick;
    int                phase;
    int                n;

    for (int k = 0; k < MAX_SECTIONS; k++) begin
      sec_start[k] = '0;
      sec_span[k]  = '0;
      sec_fbase[k] = '0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed plan. Right after reset nothing is searched, so every lookup misses.
    plan.push_back(xlat_row(IMAGE_BASE_RESET, 1'b1, '0));
    plan.push_back(xlat_row('1, 1'b1, '0));
    // Raw size larger, virtual size larger, a span that wraps, full-range sizes,
    // and the top entry with an end that wraps to zero.
    plan.push_back(load_row(4'd0, 32'h0000_1000, 32'h0000_0200, 32'h0000_0400, 32'h0000_0400));
    plan.push_back(load_row(4'd1, 32'h0000_2000, 32'h0000_1800, 32'h0000_0200, 32'h0000_0800));
    plan.push_back(load_row(4'd2, 32'hFFFF_F000, 32'h0000_2000, 32'h0, 32'hFFFF_FFFF));
    plan.push_back(load_row(4'd3, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678));
    plan.push_back(load_row(4'd15, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0));
    plan.push_back(reg_row(REG_SECTION_COUNT, 32'd1));
    plan.push_back(xlat_row(32'h0040_1000, 1'b1, xlat_res_t'{32'h400, 1'b1, 4'd0}));
    plan.push_back(xlat_row(32'h0040_2000, 1'b0, '0));
    plan.push_back(reg_row(REG_SECTION_COUNT, 32'd4));
    plan.push_back(xlat_row(32'h0040_13FF, 1'b1, xlat_res_t'{32'h7FF, 1'b1, 4'd0}));
    plan.push_back(xlat_row(32'h0040_1400, 1'b0, '0));
    plan.push_back(xlat_row(32'h0040_2000, 1'b1, xlat_res_t'{32'h800, 1'b1, 4'd1}));
    plan.push_back(xlat_row(32'h003F_F000, 1'b0, '0));
    plan.push_back(xlat_row(32'h003F_FFFF, 1'b1, '0));
    plan.push_back(reg_row(REG_IMAGE_BASE, 32'h0));
    plan.push_back(xlat_row(32'hFFFF_FFFF, 1'b1, '0));
    plan.push_back(xlat_row(32'h0, 1'b0, '0));
    plan.push_back(reg_row(REG_IMAGE_BASE, 32'hFFFF_FFFF));
    // Load fields all ones on a lookup must be ignored.
    row = xlat_row(32'h0000_0FFF, 1'b0, '0);
    row.req.idx   = '1;
    row.req.start = '1;
    row.req.vsize = '1;
    row.req.rsize = '1;
    row.req.rptr  = '1;
    plan.push_back(row);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_req(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    // Random phases. The first fills the whole table while nothing is searched,
    // so every later section count only reaches loaded entries.
    phase = 0;
    while (n_loads + n_xlat < ITEMS) begin
      if (phase == 1) base_pick = '0;
      else if (phase == 2) base_pick = '1;
      else if (phase % 4 == 3) base_pick = IMAGE_BASE_RESET;
      else base_pick = $urandom;
      if (phase == 0) count_pick = 0;
      else if (phase <= 2) count_pick = MAX_SECTIONS;
      else begin
        case ($urandom_range(0, 4))
          0: count_pick = MAX_SECTIONS;
          1: count_pick = 0;
          // Counts past the table size search every entry.
          2: count_pick = $urandom_range(MAX_SECTIONS + 1, (1 << CNT_W) - 1);
          default: count_pick = $urandom_range(1, MAX_SECTIONS);
        endcase
      end
      settle();
      write_reg(REG_IMAGE_BASE, base_pick);
      settle();
      write_reg(REG_SECTION_COUNT, count_pick);
      calm = ($urandom_range(0, 3) == 0);

      if (phase == 0) begin
        for (int k = 0; k < MAX_SECTIONS; k++) send_req(random_load(k[IDX_W-1:0]), 1'b0, '0);
      end else begin
        n = $urandom_range(20, 120);
        repeat (n) begin
          // Now and then hold off until the block has emptied.
          if ($urandom_range(0, 59) == 0) settle();
          if ($urandom_range(0, 4) == 0) begin
            r = random_load(IDX_W'($urandom_range(0, MAX_SECTIONS - 1)));
          end else begin
            r = random_translate();
          end
          send_req(r, 1'b0, '0);
        end
      end
      phase++;
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (expected_xlat.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Ran %0d loads and %0d lookups (%0d hits) over %0d phases.",
             n_loads, n_xlat, n_hits, phase);
    $display("Made %0d register writes, with image bases 0 and all ones and counts 0 to %0d.",
             n_writes, (1 << CNT_W) - 1);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
